@@ design/rwu_pkg.sv @@
// Shared types and constants for the Reno window update block.
package rwu_pkg;

    // Width of the search bit index; covers up to 32 root bits (credit of up to 63 bits)
    localparam int BIT_IDX_W = 5;

    // Configuration register indexes
    localparam logic [1:0] CFG_SEGMENT_SIZE = 2'd0;

    // Reset values of the configuration and flow state
    localparam logic [15:0] RESET_SEGMENT_SIZE = 16'd1460;
    localparam logic [31:0] RESET_WINDOW       = 32'd10;
    localparam logic [31:0] RESET_THRESHOLD    = 32'd1048575;

    // Threshold never drops below this many segments
    localparam logic [31:0] MIN_THRESHOLD = 32'd2;

    // Output field limits
    localparam logic [35:0] BYTES_MAX     = 36'hF_FFFF_FFFF;
    localparam logic [19:0] THRESHOLD_MAX = 20'hF_FFFF;

    typedef struct packed {
        logic                 capture;  // latch the input transaction
        logic                 prep;     // credit, NACK and timeout handling
        logic                 slow;     // slow start step
        logic                 ca_init;  // set up the avoidance root search
        logic                 ca_step;  // one bit of the root search
        logic                 ca_done;  // apply the search result
        logic                 mult;     // window times segment size
        logic                 load_out; // fill the output register
        logic [BIT_IDX_W-1:0] bit_idx;  // root bit under test
    } rwu_cmd_t;

    typedef struct packed {
        logic ca_go;  // congestion avoidance applies to this transaction
    } rwu_status_t;

endpackage

@@ design/rwu_ctrl.sv @@
// Sequencer for the Reno window update: handshakes and step commands.
module rwu_ctrl #(
    parameter int SEARCH_BITS = 17
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  rwu_pkg::rwu_status_t status,
    output rwu_pkg::rwu_cmd_t    cmd
);
    import rwu_pkg::*;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_PREP    = 3'd1;
    localparam logic [2:0] ST_SLOW    = 3'd2;
    localparam logic [2:0] ST_CHECK   = 3'd3;
    localparam logic [2:0] ST_SEARCH  = 3'd4;
    localparam logic [2:0] ST_CA_DONE = 3'd5;
    localparam logic [2:0] ST_MULT    = 3'd6;
    localparam logic [2:0] ST_FINISH  = 3'd7;

    logic [2:0]           state_reg, state_next;
    logic [BIT_IDX_W-1:0] bit_reg, bit_next;
    logic                 out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        bit_next       = bit_reg;
        cmd            = '0;
        cmd.bit_idx    = bit_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = ST_SLOW;
            end
            ST_SLOW:
            begin
                cmd.slow   = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                cmd.ca_init = 1'b1;
                bit_next    = BIT_IDX_W'(SEARCH_BITS - 1);
                state_next  = status.ca_go ? ST_SEARCH : ST_MULT;
            end
            ST_SEARCH:
            begin
                cmd.ca_step = 1'b1;
                if (bit_reg == '0)
                    state_next = ST_CA_DONE;
                else
                    bit_next = bit_reg - 1'b1;
            end
            ST_CA_DONE:
            begin
                cmd.ca_done = 1'b1;
                state_next  = ST_MULT;
            end
            ST_MULT:
            begin
                cmd.mult   = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // wait here only while the previous result is still unread
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bit_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bit_reg       <= bit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

`ifndef ASSERT_OFF
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && in_valid) |=> (state_reg == ST_PREP))
        else $error("accepted transaction did not start processing");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("output register overwritten while result pending");

    a_search_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH && bit_reg != '0)
            |=> (state_reg == ST_SEARCH && bit_reg == $past(bit_reg) - 1'b1))
        else $error("root search skipped a bit");

    a_search_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK && status.ca_go)
            |=> (bit_reg == BIT_IDX_W'(SEARCH_BITS - 1)))
        else $error("root search started at the wrong bit");
`endif

endmodule

@@ design/rwu_datapath.sv @@
// Window, threshold and credit arithmetic of the Reno window update.
module rwu_datapath #(
    parameter int WINDOW_WIDTH = 20,
    parameter int CREDIT_WIDTH = 32,
    parameter int SEARCH_BITS  = 17
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rwu_pkg::rwu_cmd_t    cmd,
    output rwu_pkg::rwu_status_t status,
    input  logic [15:0]          segment_size,
    input  logic [15:0]          ack_count,
    input  logic [7:0]           nack_count,
    input  logic [7:0]           timeout_count,
    output logic [35:0]          window_bytes,
    output logic [19:0]          threshold_segments,
    output logic [15:0]          acks_consumed,
    output logic                 nack_taken,
    output logic                 timeout_taken
);
    import rwu_pkg::*;

    localparam int WW  = WINDOW_WIDTH;
    localparam int CW  = CREDIT_WIDTH;
    localparam int SW  = (CW > WW) ? CW : WW;           // common compare width
    localparam int CNW = WW + SEARCH_BITS;              // window plus root
    localparam int EW  = WW + 2 * SEARCH_BITS + 2;      // search candidate
    localparam int PW  = WW + 16;                       // byte product
    localparam int XW  = (PW > 36) ? PW : 36;
    localparam int TW  = (WW > 20) ? WW : 20;

    // n(n+1)/2 increment when bit b is added to n, less its n*2^b term: 2^(2b-1) + 2^(b-1), or 1 for b = 0
    function automatic logic [EW-1:0] tri_step(input logic [BIT_IDX_W-1:0] b);
        logic [EW-1:0] r;
        if (b == '0)
            r = EW'(1);
        else
            r = (EW'(1) << (2 * int'(b) - 1)) + (EW'(1) << (int'(b) - 1));
        return r;
    endfunction

    function automatic logic [WW-1:0] floor2(input logic [WW-1:0] v);
        return (v < MIN_THRESHOLD[WW-1:0]) ? MIN_THRESHOLD[WW-1:0] : v;
    endfunction

    logic [15:0]     ack_reg;
    logic [7:0]      nack_reg;
    logic [7:0]      rto_reg;
    logic [WW-1:0]   window_reg, window_next;
    logic [WW-1:0]   thresh_reg, thresh_next;
    logic [CW-1:0]   credit_reg, credit_next;
    logic            grow_reg, grow_next;
    logic [15:0]     consumed_reg, consumed_next;
    logic [CW-1:0]   cost_reg;
    logic [CNW-1:0]  cn_reg;
    logic [PW-1:0]   prod_reg;
    logic [35:0]     bytes_reg;
    logic [19:0]     thr_out_reg;
    logic [15:0]     acks_out_reg;
    logic            nack_out_reg;
    logic            rto_out_reg;

    // prep stage signals
    logic [CW:0]     credit_sum;
    logic [CW-1:0]   credit_sat;
    logic [WW-1:0]   nack_shift;
    logic [WW-1:0]   win_a, thr_a;
    logic            nack_any;
    logic            loss_rto;

    // slow start signals
    logic [WW-1:0]   room;
    logic [SW-1:0]   use_amt;

    // root search signals
    logic [EW-1:0]   cand;
    logic            cand_ok;

    // output saturation
    logic [XW-1:0]   prod_ext;
    logic [TW-1:0]   thr_ext;

    always_comb
    begin
        credit_sum = {1'b0, credit_reg} + (CW + 1)'(ack_reg);
        credit_sat = credit_sum[CW] ? {CW{1'b1}} : credit_sum[CW-1:0];
        nack_any   = (nack_reg != '0);
        nack_shift = (int'(nack_reg) >= WW) ? '0 : (window_reg >> nack_reg);
        win_a      = nack_any ? floor2(nack_shift) : window_reg;
        thr_a      = nack_any ? floor2(nack_shift) : thresh_reg;
        loss_rto   = (rto_reg != '0) && (win_a > thr_a);
    end

    always_comb
    begin
        room    = thresh_reg - window_reg;
        use_amt = (SW'(credit_reg) < SW'(room)) ? SW'(credit_reg) : SW'(room);
    end

    assign status.ca_go = grow_reg && (SW'(credit_reg) >= SW'(window_reg))
                          && (window_reg >= thresh_reg);

    assign cand    = EW'(cost_reg) + (EW'(cn_reg) << cmd.bit_idx) + tri_step(cmd.bit_idx);
    assign cand_ok = (cand <= EW'(credit_reg));

    always_comb
    begin
        window_next   = window_reg;
        thresh_next   = thresh_reg;
        credit_next   = credit_reg;
        grow_next     = grow_reg;
        consumed_next = consumed_reg;
        if (cmd.prep)
        begin
            window_next   = loss_rto ? WW'(1) : win_a;
            thresh_next   = loss_rto ? floor2(win_a >> 1) : thr_a;
            credit_next   = (nack_any || loss_rto) ? '0 : credit_sat;
            grow_next     = !nack_any && !loss_rto && (credit_sat != '0);
            consumed_next = (!nack_any && !loss_rto && (credit_sat != '0)) ? ack_reg : '0;
        end
        else if (cmd.slow)
        begin
            if (grow_reg && (window_reg < thresh_reg))
            begin
                window_next = window_reg + use_amt[WW-1:0];
                credit_next = credit_reg - use_amt[CW-1:0];
            end
        end
        else if (cmd.ca_done)
        begin
            window_next = (cn_reg[CNW-1:WW] != '0) ? {WW{1'b1}} : cn_reg[WW-1:0];
            credit_next = credit_reg - cost_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg   <= RESET_WINDOW[WW-1:0];
            thresh_reg   <= RESET_THRESHOLD[WW-1:0];
            credit_reg   <= '0;
            grow_reg     <= 1'b0;
            consumed_reg <= '0;
        end
        else
        begin
            window_reg   <= window_next;
            thresh_reg   <= thresh_next;
            credit_reg   <= credit_next;
            grow_reg     <= grow_next;
            consumed_reg <= consumed_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ack_reg  <= ack_count;
            nack_reg <= nack_count;
            rto_reg  <= timeout_count;
        end
        // cn tracks window + n, cost tracks n*window + n(n+1)/2
        if (cmd.ca_init)
        begin
            cost_reg <= '0;
            cn_reg   <= CNW'(window_reg);
        end
        else if (cmd.ca_step && cand_ok)
        begin
            cost_reg <= cand[CW-1:0];
            cn_reg   <= cn_reg + (CNW'(1) << cmd.bit_idx);
        end
        if (cmd.mult)
            prod_reg <= PW'(window_reg) * PW'(segment_size);
        if (cmd.load_out)
        begin
            bytes_reg    <= (prod_ext > XW'(BYTES_MAX)) ? BYTES_MAX : prod_ext[35:0];
            thr_out_reg  <= (thr_ext > TW'(THRESHOLD_MAX)) ? THRESHOLD_MAX : thr_ext[19:0];
            acks_out_reg <= consumed_reg;
            nack_out_reg <= (nack_reg != '0);
            rto_out_reg  <= (rto_reg != '0);
        end
    end

    assign prod_ext = XW'(prod_reg);
    assign thr_ext  = TW'(thresh_reg);

    assign window_bytes       = bytes_reg;
    assign threshold_segments = thr_out_reg;
    assign acks_consumed      = acks_out_reg;
    assign nack_taken         = nack_out_reg;
    assign timeout_taken      = rto_out_reg;

endmodule

@@ design/reno_window_update.sv @@
// Top level of the Reno congestion window update block.
// One input transaction per scheduler invocation of a flow gives one result
// transaction. When congestion avoidance runs, the exact integer
// square-root solution of the avoidance step is found by a shift-and-add
// search that settles one root bit per cycle. The next transaction is
// accepted as soon as the result has moved to the output register, even if
// the downstream side has not yet taken it. Configuration: register 0 sets
// the segment size, which is read when the window is multiplied by it, so a
// write during a transaction can already affect that transaction; writes to
// other indexes are ignored, and reset restores the flow state to its
// defaults (10 and 1048575 segments).
module reno_window_update #(
    parameter int WINDOW_WIDTH = 20,
    parameter int CREDIT_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // ack_count[15:0], nack_count[23:16], timeout_count[31:24]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // window_bytes[35:0], threshold_segments[55:36],
                                   // acks_consumed[71:56], nack_taken[72],
                                   // timeout_taken[73], zero[79:74]
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [19:0] cfg_data
);
    import rwu_pkg::*;

    localparam int SEARCH_BITS = CREDIT_WIDTH / 2 + 1;

    logic [15:0] segment_size_reg;
    rwu_cmd_t    cmd;
    rwu_status_t status;
    logic [35:0] window_bytes;
    logic [19:0] threshold_segments;
    logic [15:0] acks_consumed;
    logic        nack_taken;
    logic        timeout_taken;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            segment_size_reg <= RESET_SEGMENT_SIZE;
        else if (cfg_wr_en && cfg_index == CFG_SEGMENT_SIZE)
            segment_size_reg <= cfg_data[15:0];
    end

    rwu_ctrl #(
        .SEARCH_BITS (SEARCH_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    rwu_datapath #(
        .WINDOW_WIDTH (WINDOW_WIDTH),
        .CREDIT_WIDTH (CREDIT_WIDTH),
        .SEARCH_BITS  (SEARCH_BITS)
    ) u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .status             (status),
        .segment_size       (segment_size_reg),
        .ack_count          (s_tdata[15:0]),
        .nack_count         (s_tdata[23:16]),
        .timeout_count      (s_tdata[31:24]),
        .window_bytes       (window_bytes),
        .threshold_segments (threshold_segments),
        .acks_consumed      (acks_consumed),
        .nack_taken         (nack_taken),
        .timeout_taken      (timeout_taken)
    );

    assign m_tdata = {6'b0, timeout_taken, nack_taken, acks_consumed,
                      threshold_segments, window_bytes};

endmodule
